// ===== hdl/tcw_pkg.sv =====
// tcw_pkg: shared types and constants for the text console writer
// holds state and mode enums, character codes and default geometry
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

    // default screen geometry
    localparam int DEFAULT_COLS = 80;
    localparam int DEFAULT_ROWS = 25;

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    // register reset value
    localparam logic [7:0] RESET_ATTR = 8'h0F;

    // character codes
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_ERROR     = 8'h45;
    localparam logic [7:0] CH_BLANK     = 8'h20;
    localparam logic [7:0] ERR_ATTR     = 8'h04;

    typedef enum logic [1:0] {
        MODE_PUT_CURSOR = 2'd0,
        MODE_PUT_CELL   = 2'd1,
        MODE_CLEAR      = 2'd2,
        MODE_READ       = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_ZERO,
        ST_CLEAR,
        ST_OUT
    } state_t;

endpackage

// ===== hdl/text_console_writer.sv =====
// text_console_writer: character-cell console with cursor, scroll and clear
// screen store is an internal single-write, registered-read memory
// depends on tcw_pkg
`timescale 1ns / 1ps

//  channel   dir  handshake           payload
//  s_        in   s_tvalid/s_tready   s_tuser: mode; s_tdata: ch, column, line, attribute
//  m_        out  m_tvalid/m_tready   m_tdata: cell_char, cell_attr, cursor, flags
//  cfg       in   cfg_wr_en           cfg_wr_data: default_attr
//
//  one transaction at a time; a plain character or an out-of-range write passes through
//  accept, execute and result, a cell read adds a memory wait state between execute and result
//  a scroll walks the screen memory with one address unit: each moved cell is read
//  (ST_SCROLL_RD) and then written (ST_SCROLL_WR), then the last row is zeroed (ST_ZERO)
//  a clear writes every cell, one cell per cycle
//  after reset a clearing pass zeroes the memory; s_tready stays low during it,
//  while a stalled result holds s_tready low too

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLS = DEFAULT_COLS,
    parameter int ROWS = DEFAULT_ROWS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,   // default_attr
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // ch[7:0], column[14:8], line[19:15],
                                                // attribute[27:20], zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,       // mode[1:0]
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata        // cell_char[7:0], cell_attr[15:8],
                                                // cursor_col[22:16], cursor_row[27:23],
                                                // scrolled[28], out_of_range[29], zero pad
);

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_MOVE   = ADDR_W'(CELLS - COLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_A  = ADDR_W'(CELLS - COLS);
    localparam logic [7:0]        COL_LIM     = 8'(COLS);
    localparam logic [5:0]        ROW_LIM     = 6'(ROWS);
    localparam logic [6:0]        COL_MAX     = 7'(COLS - 1);

    // screen store: attribute in the high byte, character in the low byte
    logic [15:0] mem [CELLS];
    logic [15:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [15:0]       mem_wd;
    logic [ADDR_W-1:0] mem_ra;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;

    // captured transaction
    mode_t      mode_reg;
    logic [7:0] ch_reg;
    logic [6:0] column_reg;
    logic [4:0] line_reg;
    logic [7:0] attribute_reg;

    logic [7:0] default_attr_reg;

    // cursor and result registers
    logic [6:0] cur_col_reg, cur_col_next;
    logic [4:0] cur_row_reg, cur_row_next;
    logic [7:0] out_char_reg, out_char_next;
    logic [7:0] out_attr_reg, out_attr_next;
    logic       scrolled_reg, scrolled_next;
    logic       oor_reg, oor_next;

    // shared address unit and put-char decode
    logic [6:0]        tgt_col;
    logic [4:0]        tgt_row;
    logic [ADDR_W-1:0] base_addr;
    logic [7:0]        attr_res;
    logic              in_screen;
    logic              at_origin;
    logic              col_last;
    logic              row_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {2'b00, oor_reg, scrolled_reg, cur_row_reg, cur_col_reg,
                       out_attr_reg, out_char_reg};

    // target cell: the cursor for mode 0, the given cell otherwise
    assign tgt_col   = (mode_reg == MODE_PUT_CURSOR) ? cur_col_reg : column_reg;
    assign tgt_row   = (mode_reg == MODE_PUT_CURSOR) ? cur_row_reg : line_reg;
    assign base_addr = ADDR_W'(tgt_row) * COLS_A + ADDR_W'(tgt_col);
    assign attr_res  = (attribute_reg == 8'h00) ? default_attr_reg : attribute_reg;
    assign in_screen = ({1'b0, column_reg} < COL_LIM) && ({1'b0, line_reg} < ROW_LIM);
    assign at_origin = (tgt_row == 5'd0) && (tgt_col == 7'd0);
    assign col_last  = (({1'b0, tgt_col} + 8'd1) == COL_LIM);
    assign row_last  = (({1'b0, tgt_row} + 6'd1) == ROW_LIM);

    // scroll reads one row below the cell being written
    assign mem_ra = (state_reg == ST_SCROLL_RD) ? (cnt_reg + COLS_A) : base_addr;

    // memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_INIT;
            cnt_reg          <= '0;
            cur_col_reg      <= '0;
            cur_row_reg      <= '0;
            default_attr_reg <= RESET_ATTR;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            if (cfg_wr_en) begin
                default_attr_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg      <= mode_t'(s_tuser);
            ch_reg        <= s_tdata[7:0];
            column_reg    <= s_tdata[14:8];
            line_reg      <= s_tdata[19:15];
            attribute_reg <= s_tdata[27:20];
        end
        out_char_reg <= out_char_next;
        out_attr_reg <= out_attr_next;
        scrolled_reg <= scrolled_next;
        oor_reg      <= oor_next;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        out_char_next = out_char_reg;
        out_attr_next = out_attr_reg;
        scrolled_next = scrolled_reg;
        oor_next      = oor_reg;
        mem_we        = 1'b0;
        mem_wa        = cnt_reg;
        mem_wd        = 16'h0000;

        unique case (state_reg)
            ST_INIT: begin
                // zero the store after reset
                mem_we = 1'b1;
                if (cnt_reg == LAST_CELL) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                out_char_next = 8'h00;
                out_attr_next = 8'h00;
                scrolled_next = 1'b0;
                oor_next      = 1'b0;
                state_next    = ST_OUT;
                unique case (mode_reg)
                    MODE_PUT_CURSOR, MODE_PUT_CELL: begin
                        if ((mode_reg == MODE_PUT_CELL) && !in_screen) begin
                            // off-screen write marks the last cell
                            mem_we   = 1'b1;
                            mem_wa   = LAST_CELL;
                            mem_wd   = {ERR_ATTR, CH_ERROR};
                            oor_next = 1'b1;
                        end else if (ch_reg == CH_BACKSPACE) begin
                            // nothing happens at the top left cell
                            if (!at_origin) begin
                                mem_we = 1'b1;
                                mem_wa = base_addr - 1'b1;
                                mem_wd = {attr_res, CH_BLANK};
                                if (tgt_col == 7'd0) begin
                                    cur_col_next = COL_MAX;
                                    cur_row_next = tgt_row - 1'b1;
                                end else begin
                                    cur_col_next = tgt_col - 1'b1;
                                    cur_row_next = tgt_row;
                                end
                            end
                        end else begin
                            if (ch_reg != CH_NEWLINE) begin
                                mem_we = 1'b1;
                                mem_wa = base_addr;
                                mem_wd = {attr_res, ch_reg};
                            end
                            if ((ch_reg == CH_NEWLINE) || col_last) begin
                                cur_col_next = 7'd0;
                                if (row_last) begin
                                    // cursor stays on the last row, screen moves up
                                    cur_row_next  = tgt_row;
                                    scrolled_next = 1'b1;
                                    cnt_next      = '0;
                                    state_next    = ST_SCROLL_RD;
                                end else begin
                                    cur_row_next = tgt_row + 1'b1;
                                end
                            end else begin
                                cur_col_next = tgt_col + 1'b1;
                                cur_row_next = tgt_row;
                            end
                        end
                    end
                    MODE_CLEAR: begin
                        cur_col_next = 7'd0;
                        cur_row_next = 5'd0;
                        cnt_next     = '0;
                        state_next   = ST_CLEAR;
                    end
                    MODE_READ: begin
                        if (!in_screen) begin
                            oor_next = 1'b1;
                        end else begin
                            state_next = ST_READ_WAIT;
                        end
                    end
                endcase
            end

            ST_READ_WAIT: begin
                out_char_next = rd_data_reg[7:0];
                out_attr_next = rd_data_reg[15:8];
                state_next    = ST_OUT;
            end

            ST_SCROLL_RD: begin
                state_next = ST_SCROLL_WR;
            end

            ST_SCROLL_WR: begin
                mem_we = 1'b1;
                mem_wd = rd_data_reg;
                if (cnt_reg == LAST_MOVE) begin
                    cnt_next   = LAST_ROW_A;
                    state_next = ST_ZERO;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_SCROLL_RD;
                end
            end

            ST_ZERO: begin
                mem_we = 1'b1;
                if (cnt_reg == LAST_CELL) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wd = {default_attr_reg, CH_BLANK};
                if (cnt_reg == LAST_CELL) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // input and result sides are never open together
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    // cursor always lies on the screen
    a_cursor_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, cur_col_reg} < COL_LIM) && ({1'b0, cur_row_reg} < ROW_LIM))
        else $error("cursor off screen");

    // an accepted transaction is executed in the next cycle
    a_exec_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted transaction not executed");

    // a scroll leaves the cursor at the start of the last row
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && scrolled_reg) |->
            ((cur_col_reg == 7'd0) && (({1'b0, cur_row_reg} + 6'd1) == ROW_LIM)))
        else $error("cursor wrong after scroll");

    // an off-screen step never scrolls
    a_oor_no_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && oor_reg) |-> !scrolled_reg)
        else $error("out-of-range step reported a scroll");

endmodule
